// ===== src/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg
// Shared widths, opcode and status codes, and item types of the quaternion
// arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int CW     = 16;                  // component width
    localparam int FB     = 14;                  // fraction bits
    localparam int PW     = 2 * CW - FB;         // floored product width
    localparam int RW     = PW + 2;              // direct result width
    localparam int SQW    = 2 * CW - 1;          // square width
    localparam int SUMW   = 2 * CW + 1;          // sum of squares width
    localparam int SQ_N   = (SUMW + 1) / 2;      // root bits
    localparam int SQ_PADW = 2 * SQ_N;
    localparam int SQ_RMW = SQ_N + 2;
    localparam int SQ_PER = 3;
    localparam int SQ_STG = (SQ_N + SQ_PER - 1) / SQ_PER;
    localparam int NW     = SQ_N;
    localparam int N2W    = SUMW - FB;
    localparam int DVW    = (N2W > NW) ? N2W : NW;
    localparam int DDW    = CW + FB;
    localparam int DV_PER = 4;
    localparam int DV_STG = (DDW + DV_PER - 1) / DV_PER;
    localparam int WW     = DDW + 2;
    localparam int NSTG   = 3 + SQ_STG + DV_STG + 1;

    localparam logic signed [WW-1:0] SMAX_W   = WW'(2 ** (CW - 1) - 1);
    localparam logic signed [WW-1:0] SMIN_W   = -SMAX_W - WW'(1);
    localparam logic signed [WW-1:0] SMAXP1_W = SMAX_W + WW'(1);
    localparam logic signed [WW-1:0] SMINM1_W = SMIN_W - WW'(1);

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_SCL  = 3'd3,
        OP_CONJ = 3'd4,
        OP_NORM = 3'd5,
        OP_NRMZ = 3'd6,
        OP_INV  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        t_op                 op;
        logic [3:0][CW-1:0]  a;
        logic [3:0][CW-1:0]  b;
        logic [CW-1:0]       s;
    } t_inq;

    typedef struct packed {
        t_op                 op;
        logic [3:0][CW-1:0]  a;
        logic [3:0][RW-1:0]  res;
        logic                sum_zero;
        logic                n2_zero;
        logic [N2W-1:0]      n2;
        logic [NW-1:0]       nrm;
    } t_side;

endpackage

// ===== src/qau_in_if.sv =====
// ----------------------------------------------------------------------------
// qau_in_if
// Input channel of the quaternion unit: opcode, quaternions a and b, scale.
// ----------------------------------------------------------------------------
interface qau_in_if import qau_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [2:0]           opcode;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] b_w;
    logic signed [CW-1:0] scale_factor;

    modport source (output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                    scale_factor, input ready);
    modport sink (input valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  scale_factor, output ready);
endinterface

// ===== src/qau_out_if.sv =====
// ----------------------------------------------------------------------------
// qau_out_if
// Output channel of the quaternion unit: result quaternion, norm and status.
// ----------------------------------------------------------------------------
interface qau_out_if import qau_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic signed [CW-1:0] r_w;
    logic [CW-1:0]        norm_value;
    logic [1:0]           status;

    modport source (output valid, r_x, r_y, r_z, r_w, norm_value, status,
                    input ready);
    modport sink (input valid, r_x, r_y, r_z, r_w, norm_value, status,
                  output ready);
endinterface

// ===== src/qau_sqrt.sv =====
// ----------------------------------------------------------------------------
// qau_sqrt
// Pipelined restoring integer square root, SQ_PER root bits per stage.
// ----------------------------------------------------------------------------
module qau_sqrt import qau_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SUMW-1:0] i_rad,
    output logic [NW-1:0]   o_root
);

    typedef struct packed {
        logic [SQ_PADW-1:0] rad;
        logic [SQ_RMW-1:0]  rem;
        logic [SQ_N-1:0]    root;
    } t_sq;

    t_sq r_st [SQ_STG];
    t_sq n_st [SQ_STG];

    function automatic t_sq sq_step(input t_sq s);
        logic [SQ_RMW-1:0] t;
        logic [SQ_RMW-1:0] trial;
        t_sq o;
        t     = {s.rem[SQ_RMW-3:0], s.rad[SQ_PADW-1 -: 2]};
        trial = {s.root, 2'b01};
        o.rad = {s.rad[SQ_PADW-3:0], 2'b00};
        if (t >= trial) begin
            o.rem  = t - trial;
            o.root = {s.root[SQ_N-2:0], 1'b1};
        end else begin
            o.rem  = t;
            o.root = {s.root[SQ_N-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        t_sq cur;
        for (int k = 0; k < SQ_STG; k++) begin
            if (k == 0) begin
                cur.rad  = SQ_PADW'(i_rad);
                cur.rem  = '0;
                cur.root = '0;
            end else begin
                cur = r_st[k-1];
            end
            for (int j = 0; j < SQ_PER; j++) begin
                if (k * SQ_PER + j < SQ_N) begin
                    cur = sq_step(cur);
                end
            end
            n_st[k] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STG; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_root = r_st[SQ_STG-1].root;

endmodule

// ===== src/qau_div.sv =====
// ----------------------------------------------------------------------------
// qau_div
// Pipelined restoring divider, four lanes sharing one divisor.
// ----------------------------------------------------------------------------
module qau_div import qau_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [3:0][DDW-1:0] i_dd,
    input  logic [DVW-1:0]      i_dv,
    output logic [3:0][DDW-1:0] o_q
);

    typedef struct packed {
        logic [3:0][DDW-1:0] dd;
        logic [3:0][DVW:0]   rem;
        logic [3:0][DDW-1:0] q;
        logic [DVW-1:0]      dv;
    } t_dv;

    t_dv r_st [DV_STG];
    t_dv n_st [DV_STG];

    function automatic t_dv dv_step(input t_dv s);
        logic [DVW:0] t;
        t_dv o;
        o = s;
        for (int l = 0; l < 4; l++) begin
            t = {s.rem[l][DVW-1:0], s.dd[l][DDW-1]};
            o.dd[l] = {s.dd[l][DDW-2:0], 1'b0};
            if (t >= {1'b0, s.dv}) begin
                o.rem[l] = t - {1'b0, s.dv};
                o.q[l]   = {s.q[l][DDW-2:0], 1'b1};
            end else begin
                o.rem[l] = t;
                o.q[l]   = {s.q[l][DDW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    always_comb begin
        t_dv cur;
        for (int k = 0; k < DV_STG; k++) begin
            if (k == 0) begin
                cur.dd  = i_dd;
                cur.rem = '0;
                cur.q   = '0;
                cur.dv  = i_dv;
            end else begin
                cur = r_st[k-1];
            end
            for (int j = 0; j < DV_PER; j++) begin
                if (k * DV_PER + j < DDW) begin
                    cur = dv_step(cur);
                end
            end
            n_st[k] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DV_STG; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_q = r_st[DV_STG-1].q;

endmodule

// ===== src/quaternion_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Stateless quaternion ALU in signed Q2.14 with a fixed-depth pipeline.
// ----------------------------------------------------------------------------
// usage
//   i_in carries one item: opcode, quaternions a and b, scale factor
//   o_out returns one result item per input item, in order
//   each item passes the input, product, sum, root, divider and output registers
//   one item per cycle is accepted while the pipeline is not held; the path
//   is set by the square root (six stages, up to three root bits each) and
//   the divider for normalize and inverse (eight stages, up to four quotient
//   bits each); all opcodes share the same path so results stay in order
//   products, squares and sums take the first three stages
//   reset (i_rst_n low, synchronous) clears all valid bits
//   when o_out.ready is low with a result waiting, the whole pipeline
//   holds and i_in.ready drops in the same cycle; nothing is lost
//   norm_value is the norm of a, given for every opcode
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qau_in_if.sink     i_in,
    qau_out_if.source  o_out
);

    typedef struct packed {
        logic [3:0][CW-1:0] r;
        logic [CW-1:0]      nv;
        t_status            st;
    } t_res;

    logic [NSTG-1:0]          r_vld;
    logic                     w_en;

    t_inq                     r_a;
    t_inq                     n_a;
    t_inq                     r_b;
    logic [3:0][3:0][PW-1:0]  r_p;
    logic [3:0][3:0][PW-1:0]  n_p;
    logic [3:0][PW-1:0]       r_ps;
    logic [3:0][PW-1:0]       n_ps;
    logic [3:0][SQW-1:0]      r_sq;
    logic [3:0][SQW-1:0]      n_sq;
    t_side                    r_c;
    t_side                    n_c;
    logic [SUMW-1:0]          r_sum;
    logic [SUMW-1:0]          n_sum;
    t_side                    r_sd [SQ_STG];
    t_side                    r_dd [DV_STG];
    t_side                    n_dd0;
    logic [NW-1:0]            w_root;
    logic [3:0][DDW-1:0]      w_dd;
    logic [DVW-1:0]           w_dv;
    logic [3:0][DDW-1:0]      w_q;
    t_res                     r_o;
    t_res                     n_o;

    assign w_en       = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    // input stage
    always_comb begin
        n_a.op = t_op'(i_in.opcode);
        n_a.a  = {i_in.a_w, i_in.a_z, i_in.a_y, i_in.a_x};
        n_a.b  = {i_in.b_w, i_in.b_z, i_in.b_y, i_in.b_x};
        n_a.s  = i_in.scale_factor;
    end

    // floored products and squares
    always_comb begin
        logic signed [2*CW-1:0] prod;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                prod       = $signed(r_a.a[i]) * $signed(r_a.b[j]);
                n_p[i][j]  = prod[2*CW-1:FB];
            end
            prod    = $signed(r_a.a[i]) * $signed(r_a.s);
            n_ps[i] = prod[2*CW-1:FB];
            prod    = $signed(r_a.a[i]) * $signed(r_a.a[i]);
            n_sq[i] = prod[SQW-1:0];
        end
    end

    // direct results and sum of squares
    always_comb begin
        logic signed [RW-1:0] pe [4][4];
        logic signed [RW-1:0] sa;
        logic signed [RW-1:0] sb;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                pe[i][j] = RW'($signed(r_p[i][j]));
            end
        end
        n_sum = SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]) + SUMW'(r_sq[3]);
        n_c.op       = r_b.op;
        n_c.a        = r_b.a;
        n_c.n2       = n_sum[SUMW-1:FB];
        n_c.sum_zero = (n_sum == '0);
        n_c.n2_zero  = (n_sum[SUMW-1:FB] == '0);
        n_c.nrm      = '0;
        for (int i = 0; i < 4; i++) begin
            sa = RW'($signed(r_b.a[i]));
            sb = RW'($signed(r_b.b[i]));
            case (r_b.op)
                OP_ADD:  n_c.res[i] = sa + sb;
                OP_SUB:  n_c.res[i] = sa - sb;
                OP_SCL:  n_c.res[i] = RW'($signed(r_ps[i]));
                OP_CONJ: n_c.res[i] = (i < 3) ? -sa : sa;
                default: n_c.res[i] = '0;
            endcase
        end
        if (r_b.op == OP_MUL) begin
            n_c.res[0] = pe[3][0] + pe[0][3] + pe[1][2] - pe[2][1];
            n_c.res[1] = pe[3][1] + pe[1][3] + pe[2][0] - pe[0][2];
            n_c.res[2] = pe[3][2] + pe[2][3] + pe[0][1] - pe[1][0];
            n_c.res[3] = pe[3][3] - pe[0][0] - pe[1][1] - pe[2][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a   <= n_a;
            r_b   <= r_a;
            r_p   <= n_p;
            r_ps  <= n_ps;
            r_sq  <= n_sq;
            r_c   <= n_c;
            r_sum <= n_sum;
        end
    end

    qau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_sum),
        .o_root (w_root)
    );

    // divider operands
    always_comb begin
        logic [CW-1:0] mag;
        for (int i = 0; i < 4; i++) begin
            mag     = r_sd[SQ_STG-1].a[i][CW-1] ? (~r_sd[SQ_STG-1].a[i] + CW'(1))
                                                 : r_sd[SQ_STG-1].a[i];
            w_dd[i] = {mag, {FB{1'b0}}};
        end
        w_dv = (r_sd[SQ_STG-1].op == OP_INV) ? DVW'(r_sd[SQ_STG-1].n2) : DVW'(w_root);
        n_dd0     = r_sd[SQ_STG-1];
        n_dd0.nrm = w_root;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r_c;
            for (int k = 1; k < SQ_STG; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_dd[0] <= n_dd0;
            for (int k = 1; k < DV_STG; k++) begin
                r_dd[k] <= r_dd[k-1];
            end
        end
    end

    qau_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dd  (w_dd),
        .i_dv  (w_dv),
        .o_q   (w_q)
    );

    // result select and saturation
    always_comb begin
        t_side                s;
        logic signed [WW-1:0] qs;
        logic signed [WW-1:0] wv;
        logic                 neg;
        logic                 nz;
        logic                 sat;
        s   = r_dd[DV_STG-1];
        sat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            nz = (s.a[i] != '0);
            if (s.op == OP_INV && i < 3) begin
                neg = !s.a[i][CW-1] && nz;
            end else begin
                neg = s.a[i][CW-1];
            end
            qs = neg ? -$signed({2'b00, w_q[i]}) : $signed({2'b00, w_q[i]});
            case (s.op) inside
                OP_ADD, OP_SUB, OP_MUL, OP_SCL, OP_CONJ: wv = WW'($signed(s.res[i]));
                OP_NRMZ: wv = s.sum_zero ? '0 : qs;
                OP_INV: begin
                    if (s.sum_zero) begin
                        wv = '0;
                    end else if (s.n2_zero) begin
                        wv = !nz ? '0 : (neg ? SMINM1_W : SMAXP1_W);
                    end else begin
                        wv = qs;
                    end
                end
                default: wv = '0;
            endcase
            if (wv > SMAX_W) begin
                sat      = 1'b1;
                n_o.r[i] = SMAX_W[CW-1:0];
            end else if (wv < SMIN_W) begin
                sat      = 1'b1;
                n_o.r[i] = SMIN_W[CW-1:0];
            end else begin
                n_o.r[i] = wv[CW-1:0];
            end
        end
        if (s.op == OP_NORM && s.nrm[NW-1]) begin
            sat = 1'b1;
        end
        n_o.nv = s.nrm[NW-1] ? {CW{1'b1}} : s.nrm[CW-1:0];
        if (s.op == OP_INV && s.sum_zero) begin
            n_o.st = ST_ZERO;
        end else if (sat) begin
            n_o.st = ST_SAT;
        end else begin
            n_o.st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o <= n_o;
        end
    end

    assign o_out.valid      = r_vld[NSTG-1];
    assign o_out.r_x        = r_o.r[0];
    assign o_out.r_y        = r_o.r[1];
    assign o_out.r_z        = r_o.r[2];
    assign o_out.r_w        = r_o.r[3];
    assign o_out.norm_value = r_o.nv;
    assign o_out.status     = r_o.st;

endmodule
